// File: hw/rtl/rlt_pkg.sv
// shared types and codes for the request lifecycle table
`timescale 1ns / 1ps
package rlt_pkg;

   localparam int SlotCount  = 16;
   localparam int CountWidth = $clog2(SlotCount + 1);

   localparam logic [1:0] CmdSubmit = 2'd0;
   localparam logic [1:0] CmdMove   = 2'd1;
   localparam logic [1:0] CmdCancel = 2'd2;

   localparam logic [2:0] StSubmitted = 3'd0;
   localparam logic [2:0] StQueued    = 3'd1;
   localparam logic [2:0] StActive    = 3'd2;
   localparam logic [2:0] StComplete  = 3'd3;
   localparam logic [2:0] StFailed    = 3'd4;
   localparam logic [2:0] StCanceled  = 3'd5;

   localparam logic [2:0] StatusOk      = 3'd0;
   localparam logic [2:0] StatusFull    = 3'd1;
   localparam logic [2:0] StatusNoEnt   = 3'd2;
   localparam logic [2:0] StatusDenied  = 3'd3;
   localparam logic [2:0] StatusIllegal = 3'd4;

   typedef struct packed {
      logic        valid;
      logic        done;
      logic [1:0]  command;
      logic [63:0] request_id;
      logic [2:0]  target_state;
      logic [31:0] owner_tag;
      logic [31:0] requester_tag;
      logic        requester_valid;
      logic        admin;
      logic [63:0] new_id;
      logic [2:0]  status;
      logic [2:0]  entry_state;
      logic        count_up;
      logic        count_down;
   } packet_type;

endpackage

// File: hw/rtl/rlt_cell.sv
// one slot of the table, acting on the packet that passes through it
`timescale 1ns / 1ps
module rlt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  rlt_pkg::packet_type pkt_in,
   output rlt_pkg::packet_type pkt_out
);

   logic                used_ff, used_in;
   logic [63:0]         id_ff, id_in;
   logic [2:0]          state_ff, state_in;
   logic [31:0]         owner_ff, owner_in;
   rlt_pkg::packet_type pkt_ff, pkt_in_next;
   logic [2:0]          to_state;

   function automatic logic terminal_state(input logic [2:0] s);
      return s == rlt_pkg::StComplete || s == rlt_pkg::StFailed ||
             s == rlt_pkg::StCanceled;
   endfunction

   function automatic logic move_legal(input logic [2:0] from, input logic [2:0] to);
      logic ok;
      ok = 1'b0;
      if (from == rlt_pkg::StSubmitted) begin
         ok = to == rlt_pkg::StQueued || to == rlt_pkg::StCanceled;
      end else if (from == rlt_pkg::StQueued) begin
         ok = to == rlt_pkg::StActive || to == rlt_pkg::StCanceled ||
              to == rlt_pkg::StFailed;
      end else if (from == rlt_pkg::StActive) begin
         ok = to == rlt_pkg::StComplete || to == rlt_pkg::StFailed ||
              to == rlt_pkg::StCanceled;
      end
      return ok;
   endfunction

   always_comb begin
      pkt_in_next = pkt_in;
      used_in     = used_ff;
      id_in       = id_ff;
      state_in    = state_ff;
      owner_in    = owner_ff;
      to_state    = (pkt_in.command == rlt_pkg::CmdCancel) ? rlt_pkg::StCanceled
                                                           : pkt_in.target_state;
      if (pkt_in.valid && !pkt_in.done) begin
         unique case (pkt_in.command)
            rlt_pkg::CmdSubmit: begin
               if (!used_ff) begin
                  used_in                 = 1'b1;
                  id_in                   = pkt_in.new_id;
                  state_in                = rlt_pkg::StSubmitted;
                  owner_in                = pkt_in.owner_tag;
                  pkt_in_next.done        = 1'b1;
                  pkt_in_next.status      = rlt_pkg::StatusOk;
                  pkt_in_next.entry_state = rlt_pkg::StSubmitted;
                  pkt_in_next.count_up    = 1'b1;
               end
            end
            rlt_pkg::CmdMove, rlt_pkg::CmdCancel: begin
               if (used_ff && id_ff == pkt_in.request_id) begin
                  pkt_in_next.done = 1'b1;
                  if (pkt_in.command == rlt_pkg::CmdCancel && !pkt_in.admin &&
                      (!pkt_in.requester_valid || pkt_in.requester_tag != owner_ff)) begin
                     pkt_in_next.status      = rlt_pkg::StatusDenied;
                     pkt_in_next.entry_state = state_ff;
                  end else if (move_legal(state_ff, to_state)) begin
                     state_in                = to_state;
                     pkt_in_next.status      = rlt_pkg::StatusOk;
                     pkt_in_next.entry_state = to_state;
                     pkt_in_next.count_down  = !terminal_state(state_ff) &&
                                               terminal_state(to_state);
                  end else begin
                     pkt_in_next.status      = rlt_pkg::StatusIllegal;
                     pkt_in_next.entry_state = state_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         pkt_ff.valid <= 1'b0;
      end else if (advance) begin
         used_ff <= used_in;
         pkt_ff  <= pkt_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         id_ff    <= id_in;
         state_ff <= state_in;
         owner_ff <= owner_in;
      end
   end

   assign pkt_out = pkt_ff;

endmodule

// File: hw/rtl/request_lifecycle_table.sv
// top level of the request lifecycle table: entry, slot chain and result register
`timescale 1ns / 1ps
// A request beat enters a chain of slot cells and moves one cell per clock
// unless a result held by rsp_stall blocks the end of the chain; the lowest
// free or matching slot acts on it as it passes. The result is registered as
// the beat leaves the chain, and the next request is taken only after the
// previous one has left it, so the chain never holds two requests. A new request
// may walk the chain while the previous result still waits on rsp_stall.
module request_lifecycle_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_request_id,
   input  logic [2:0]  req_target_state,
   input  logic [31:0] req_owner_tag,
   input  logic [31:0] req_requester_tag,
   input  logic        req_requester_valid,
   input  logic        req_admin,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_entry_id,
   output logic [2:0]  rsp_entry_state,
   output logic [4:0]  rsp_active_count
);

   localparam int WideWidth = (rlt_pkg::CountWidth > 5) ? rlt_pkg::CountWidth : 5;
   localparam logic [rlt_pkg::CountWidth-1:0] CountOne = 1;

   rlt_pkg::packet_type                chain [rlt_pkg::SlotCount + 1];
   rlt_pkg::packet_type                head_pkt;
   rlt_pkg::packet_type                last_pkt;
   logic                               accept, advance, exit_now;
   logic                               busy_ff, busy_in;
   logic [63:0]                        next_id_ff, next_id_in;
   logic [rlt_pkg::CountWidth-1:0]     live_ff, live_in;
   logic [WideWidth-1:0]               live_wide;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [2:0]                         status_ff, status_in;
   logic [63:0]                        entry_id_ff, entry_id_in;
   logic [2:0]                         entry_state_ff, entry_state_in;
   logic [4:0]                         count_ff, count_in;

   assign accept   = req_valid && !busy_ff;
   assign last_pkt = chain[rlt_pkg::SlotCount];
   assign exit_now = last_pkt.valid && (!rsp_valid_ff || !rsp_stall);
   assign advance  = !last_pkt.valid || exit_now;

   always_comb begin
      head_pkt                 = '0;
      head_pkt.valid           = accept;
      head_pkt.command         = req_command;
      head_pkt.request_id      = req_request_id;
      head_pkt.target_state    = req_target_state;
      head_pkt.owner_tag       = req_owner_tag;
      head_pkt.requester_tag   = req_requester_tag;
      head_pkt.requester_valid = req_requester_valid;
      head_pkt.admin           = req_admin;
      head_pkt.new_id          = next_id_ff;
      head_pkt.status          = rlt_pkg::StatusOk;
      head_pkt.entry_state     = rlt_pkg::StSubmitted;
   end

   assign chain[0] = head_pkt;

   for (genvar k = 0; k < rlt_pkg::SlotCount; k++) begin : g_cell
      rlt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .pkt_in  (chain[k]),
         .pkt_out (chain[k+1])
      );
   end

   always_comb begin
      busy_in        = busy_ff;
      next_id_in     = next_id_ff;
      live_in        = live_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      status_in      = status_ff;
      entry_id_in    = entry_id_ff;
      entry_state_in = entry_state_ff;
      count_in       = count_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (exit_now) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         if (last_pkt.count_up) begin
            next_id_in = next_id_ff + 64'd1;
            live_in    = live_ff + CountOne;
         end
         if (last_pkt.count_down && live_ff != '0) begin
            live_in = live_ff - CountOne;
         end
         if (last_pkt.done) begin
            status_in      = last_pkt.status;
            entry_state_in = last_pkt.entry_state;
         end else begin
            entry_state_in = rlt_pkg::StSubmitted;
            unique case (last_pkt.command)
               rlt_pkg::CmdSubmit:                  status_in = rlt_pkg::StatusFull;
               rlt_pkg::CmdMove, rlt_pkg::CmdCancel: status_in = rlt_pkg::StatusNoEnt;
               default:                             status_in = rlt_pkg::StatusIllegal;
            endcase
         end
         if (last_pkt.command == rlt_pkg::CmdSubmit) begin
            entry_id_in = last_pkt.done ? last_pkt.new_id : 64'd0;
         end else begin
            entry_id_in = last_pkt.request_id;
         end
      end
      live_wide = WideWidth'(live_in);
      if (exit_now) begin
         count_in = (live_wide > WideWidth'(31)) ? 5'd31 : live_wide[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         next_id_ff   <= 64'd1;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         next_id_ff   <= next_id_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      entry_id_ff    <= entry_id_in;
      entry_state_ff <= entry_state_in;
      count_ff       <= count_in;
   end

   assign req_stall        = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_id     = entry_id_ff;
   assign rsp_entry_state  = entry_state_ff;
   assign rsp_active_count = count_ff;

endmodule

// File: tb/tb_request_lifecycle_table.sv
// self-checking testbench for the request lifecycle table: directed rows, then random traffic
`timescale 1ns / 1ps
module tb_request_lifecycle_table;

   localparam logic [1:0]  CmdUnused    = 2'd3;
   localparam logic [2:0]  StReservedLo = 3'd6;
   localparam logic [2:0]  StReservedHi = 3'd7;
   localparam logic [63:0] IdMax        = '1;
   localparam logic [31:0] TagMax       = '1;
   localparam int RandomItems = 1880;
   localparam int IdleLimit   = 5000;
   localparam int HoldAfter   = 150;
   localparam int HoldCycles  = 400;
   localparam int TailCycles  = 40;

   typedef struct {
      logic [1:0]  cmd;
      logic [63:0] id;
      logic [2:0]  target;
      logic [31:0] owner;
      logic [31:0] requester;
      logic        rv;
      logic        admin;
   } lifecycle_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [63:0] entry_id;
      logic [2:0]  entry_state;
      logic [4:0]  active_count;
   } lifecycle_rsp_type;

   typedef struct {
      lifecycle_req_type req;
      int                reps;
      bit                typed;
      lifecycle_rsp_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = rlt_pkg::CmdSubmit;
   logic [63:0] req_request_id = '0;
   logic [2:0]  req_target_state = rlt_pkg::StSubmitted;
   logic [31:0] req_owner_tag = '0;
   logic [31:0] req_requester_tag = '0;
   logic        req_requester_valid = 1'b0;
   logic        req_admin = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_entry_id;
   logic [2:0]  rsp_entry_state;
   logic [4:0]  rsp_active_count;

   // predicted table contents
   logic        tbl_used  [rlt_pkg::SlotCount];
   logic [63:0] tbl_id    [rlt_pkg::SlotCount];
   logic [2:0]  tbl_state [rlt_pkg::SlotCount];
   logic [31:0] tbl_owner [rlt_pkg::SlotCount];
   logic [63:0] next_id;
   int          live;

   lifecycle_rsp_type pending_results[$];
   directed_row_type  rows[$];
   int mismatches = 0;
   int results_checked = 0;
   bit quiet = 1'b0;
   bit hold_done = 1'b0;

   request_lifecycle_table DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_request_id(req_request_id),
      .req_target_state(req_target_state), .req_owner_tag(req_owner_tag),
      .req_requester_tag(req_requester_tag), .req_requester_valid(req_requester_valid),
      .req_admin(req_admin),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_entry_id(rsp_entry_id),
      .rsp_entry_state(rsp_entry_state), .rsp_active_count(rsp_active_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit terminal_state(input logic [2:0] s);
      return s == rlt_pkg::StComplete || s == rlt_pkg::StFailed ||
             s == rlt_pkg::StCanceled;
   endfunction

   function automatic bit is_legal_move(input logic [2:0] from, input logic [2:0] to);
      unique case (from)
         rlt_pkg::StSubmitted:
            return to == rlt_pkg::StQueued || to == rlt_pkg::StCanceled;
         rlt_pkg::StQueued:
            return to == rlt_pkg::StActive || to == rlt_pkg::StCanceled ||
                   to == rlt_pkg::StFailed;
         rlt_pkg::StActive:
            return to == rlt_pkg::StComplete || to == rlt_pkg::StFailed ||
                   to == rlt_pkg::StCanceled;
         default:
            return 1'b0;
      endcase
   endfunction

   function automatic int find_slot(input logic [63:0] id);
      int k;
      k = -1;
      for (int i = rlt_pkg::SlotCount - 1; i >= 0; i--) begin
         if (tbl_used[i] && tbl_id[i] == id) k = i;
      end
      return k;
   endfunction

   function automatic lifecycle_rsp_type apply_request(input lifecycle_req_type r);
      lifecycle_rsp_type o;
      int k;
      logic [2:0] to;
      o.status = rlt_pkg::StatusOk;
      o.entry_id = r.id;
      o.entry_state = rlt_pkg::StSubmitted;
      if (r.cmd == rlt_pkg::CmdSubmit) begin
         o.entry_id = '0;
         k = -1;
         for (int i = rlt_pkg::SlotCount - 1; i >= 0; i--) begin
            if (!tbl_used[i]) k = i;
         end
         if (k < 0) begin
            o.status = rlt_pkg::StatusFull;
         end else begin
            tbl_used[k] = 1'b1;
            tbl_id[k] = next_id;
            tbl_state[k] = rlt_pkg::StSubmitted;
            tbl_owner[k] = r.owner;
            o.entry_id = next_id;
            next_id = next_id + 64'd1;
            live++;
         end
      end else if (r.cmd == rlt_pkg::CmdMove || r.cmd == rlt_pkg::CmdCancel) begin
         k = find_slot(r.id);
         if (k < 0) begin
            o.status = rlt_pkg::StatusNoEnt;
         end else if (r.cmd == rlt_pkg::CmdCancel && !r.admin &&
                      (!r.rv || r.requester != tbl_owner[k])) begin
            o.status = rlt_pkg::StatusDenied;
            o.entry_state = tbl_state[k];
         end else begin
            to = (r.cmd == rlt_pkg::CmdCancel) ? rlt_pkg::StCanceled : r.target;
            if (!is_legal_move(tbl_state[k], to)) begin
               o.status = rlt_pkg::StatusIllegal;
            end else begin
               if (!terminal_state(tbl_state[k]) && terminal_state(to) && live > 0) live--;
               tbl_state[k] = to;
            end
            o.entry_state = tbl_state[k];
         end
      end else begin
         o.status = rlt_pkg::StatusIllegal;
      end
      o.active_count = (live > 31) ? 5'd31 : 5'(live);
      return o;
   endfunction

   function automatic logic [2:0] legal_successor(input logic [2:0] from);
      int pick;
      pick = $urandom_range(0, 2);
      unique case (from)
         rlt_pkg::StSubmitted:
            return pick[0] ? rlt_pkg::StQueued : rlt_pkg::StCanceled;
         rlt_pkg::StQueued:
            return pick == 0 ? rlt_pkg::StActive
                             : (pick == 1 ? rlt_pkg::StCanceled : rlt_pkg::StFailed);
         rlt_pkg::StActive:
            return pick == 0 ? rlt_pkg::StComplete
                             : (pick == 1 ? rlt_pkg::StFailed : rlt_pkg::StCanceled);
         default:
            return 3'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic lifecycle_req_type random_request();
      lifecycle_req_type r;
      int pick;
      int k;
      pick = $urandom_range(0, 99);
      if (pick < 50) r.cmd = rlt_pkg::CmdMove;
      else if (pick < 85) r.cmd = rlt_pkg::CmdCancel;
      else if (pick < 97) r.cmd = rlt_pkg::CmdSubmit;
      else r.cmd = CmdUnused;
      r.owner = $urandom;
      r.requester = $urandom;
      r.rv = ($urandom_range(0, 99) < 85);
      r.admin = ($urandom_range(0, 4) == 0);
      r.target = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 80 && next_id > 64'd1) r.id = 64'($urandom_range(1, int'(next_id - 64'd1)));
      else if (pick < 88) r.id = {$urandom, $urandom};
      else if (pick < 95) r.id = next_id;
      else r.id = '0;
      k = find_slot(r.id);
      if (k >= 0) begin
         if ($urandom_range(0, 99) < 65) r.target = legal_successor(tbl_state[k]);
         if ($urandom_range(0, 99) < 70) r.requester = tbl_owner[k];
      end
      return r;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   task automatic add_beat(input logic [1:0] cmd, input logic [63:0] id,
                           input logic [2:0] target, input logic [31:0] owner,
                           input logic [31:0] requester, input logic rv,
                           input logic admin, input int reps);
      directed_row_type row;
      row.req = '{cmd, id, target, owner, requester, rv, admin};
      row.reps = reps;
      row.typed = 1'b0;
      row.want = '{rlt_pkg::StatusOk, '0, rlt_pkg::StSubmitted, '0};
      rows.push_back(row);
   endtask

   task automatic known_result(input logic [2:0] status, input logic [63:0] id,
                               input logic [2:0] st, input logic [4:0] count);
      rows[rows.size() - 1].typed = 1'b1;
      rows[rows.size() - 1].want = '{status, id, st, count};
   endtask

   task automatic send_item(input lifecycle_req_type r, input int gap, input bit typed,
                            input lifecycle_rsp_type want);
      lifecycle_rsp_type predicted;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_command <= r.cmd;
      req_request_id <= r.id;
      req_target_state <= r.target;
      req_owner_tag <= r.owner;
      req_requester_tag <= r.requester;
      req_requester_valid <= r.rv;
      req_admin <= r.admin;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = apply_request(r);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // stimulus
   initial begin
      lifecycle_req_type r;
      lifecycle_rsp_type none;
      none = '{rlt_pkg::StatusOk, '0, rlt_pkg::StSubmitted, '0};
      for (int i = 0; i < rlt_pkg::SlotCount; i++) begin
         tbl_used[i] = 1'b0;
         tbl_id[i] = '0;
         tbl_state[i] = rlt_pkg::StSubmitted;
         tbl_owner[i] = '0;
      end
      next_id = 64'd1;
      live = 0;

      add_beat(rlt_pkg::CmdMove, 64'd1, rlt_pkg::StQueued, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusNoEnt, 64'd1, rlt_pkg::StSubmitted, 5'd0);
      add_beat(rlt_pkg::CmdSubmit, '0, rlt_pkg::StSubmitted, TagMax, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusOk, 64'd1, rlt_pkg::StSubmitted, 5'd1);
      add_beat(rlt_pkg::CmdSubmit, '0, rlt_pkg::StSubmitted, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusOk, 64'd2, rlt_pkg::StSubmitted, 5'd2);
      // requester not given, even though the tag matches the empty owner
      add_beat(rlt_pkg::CmdCancel, 64'd2, rlt_pkg::StSubmitted, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusDenied, 64'd2, rlt_pkg::StSubmitted, 5'd2);
      add_beat(rlt_pkg::CmdCancel, 64'd2, rlt_pkg::StSubmitted, '0, '0, 1'b1, 1'b0, 1);
      known_result(rlt_pkg::StatusOk, 64'd2, rlt_pkg::StCanceled, 5'd1);
      add_beat(rlt_pkg::CmdMove, 64'd2, rlt_pkg::StQueued, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusIllegal, 64'd2, rlt_pkg::StCanceled, 5'd1);
      add_beat(rlt_pkg::CmdMove, 64'd1, StReservedHi, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusIllegal, 64'd1, rlt_pkg::StSubmitted, 5'd1);
      add_beat(rlt_pkg::CmdMove, 64'd1, StReservedLo, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusIllegal, 64'd1, rlt_pkg::StSubmitted, 5'd1);
      add_beat(rlt_pkg::CmdMove, 64'd1, rlt_pkg::StSubmitted, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusIllegal, 64'd1, rlt_pkg::StSubmitted, 5'd1);
      add_beat(rlt_pkg::CmdMove, 64'd1, rlt_pkg::StQueued, '0, '0, 1'b0, 1'b0, 1);
      add_beat(rlt_pkg::CmdMove, 64'd1, rlt_pkg::StActive, '0, '0, 1'b0, 1'b0, 1);
      add_beat(rlt_pkg::CmdCancel, 64'd1, rlt_pkg::StSubmitted, '0, 32'h1234_5678,
               1'b1, 1'b0, 1);
      known_result(rlt_pkg::StatusDenied, 64'd1, rlt_pkg::StActive, 5'd1);
      add_beat(rlt_pkg::CmdCancel, 64'd1, rlt_pkg::StSubmitted, '0, '0, 1'b0, 1'b1, 1);
      known_result(rlt_pkg::StatusOk, 64'd1, rlt_pkg::StCanceled, 5'd0);
      add_beat(CmdUnused, IdMax, StReservedHi, TagMax, TagMax, 1'b1, 1'b1, 1);
      known_result(rlt_pkg::StatusIllegal, IdMax, rlt_pkg::StSubmitted, 5'd0);
      add_beat(rlt_pkg::CmdMove, IdMax, rlt_pkg::StQueued, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusNoEnt, IdMax, rlt_pkg::StSubmitted, 5'd0);
      add_beat(rlt_pkg::CmdMove, '0, rlt_pkg::StQueued, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusNoEnt, '0, rlt_pkg::StSubmitted, 5'd0);
      add_beat(rlt_pkg::CmdSubmit, '0, rlt_pkg::StSubmitted, TagMax, '0, 1'b0, 1'b0, 1);
      // fill the rest of the table with random owners
      add_beat(rlt_pkg::CmdSubmit, '0, rlt_pkg::StSubmitted, '0, '0, 1'b0, 1'b0,
               rlt_pkg::SlotCount - 3);
      add_beat(rlt_pkg::CmdSubmit, '0, rlt_pkg::StSubmitted, TagMax, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusFull, '0, rlt_pkg::StSubmitted, 5'd14);
      add_beat(rlt_pkg::CmdCancel, 64'd3, rlt_pkg::StSubmitted, '0, TagMax - 32'd1,
               1'b1, 1'b0, 1);
      known_result(rlt_pkg::StatusDenied, 64'd3, rlt_pkg::StSubmitted, 5'd14);
      add_beat(rlt_pkg::CmdCancel, 64'd3, rlt_pkg::StSubmitted, '0, TagMax, 1'b1, 1'b0, 1);
      known_result(rlt_pkg::StatusOk, 64'd3, rlt_pkg::StCanceled, 5'd13);
      add_beat(rlt_pkg::CmdMove, 64'd4, rlt_pkg::StQueued, '0, '0, 1'b0, 1'b0, 1);
      add_beat(rlt_pkg::CmdMove, 64'd4, rlt_pkg::StFailed, '0, '0, 1'b0, 1'b0, 1);
      add_beat(rlt_pkg::CmdMove, 64'd5, rlt_pkg::StQueued, '0, '0, 1'b0, 1'b0, 1);
      add_beat(rlt_pkg::CmdMove, 64'd5, rlt_pkg::StActive, '0, '0, 1'b0, 1'b0, 1);
      add_beat(rlt_pkg::CmdMove, 64'd5, rlt_pkg::StComplete, '0, '0, 1'b0, 1'b0, 1);
      add_beat(rlt_pkg::CmdMove, 64'd5, rlt_pkg::StCanceled, '0, '0, 1'b0, 1'b0, 1);
      known_result(rlt_pkg::StatusIllegal, 64'd5, rlt_pkg::StComplete, 5'd11);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         for (int n = 0; n < rows[i].reps; n++) begin
            r = rows[i].req;
            if (rows[i].reps > 1) r.owner = $urandom;
            send_item(r, idle_len(), rows[i].typed, rows[i].want);
         end
      end

      for (int n = 0; n < RandomItems; n++) begin
         quiet = (n >= 400 && n < 600);
         if (n == 900) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         send_item(random_request(), quiet ? 0 : idle_len(), 1'b0, none);
      end
      quiet = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // result side backpressure
   initial begin
      int run_left;
      run_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (!hold_done && results_checked >= HoldAfter) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
         end else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            run_left = $urandom_range(0, 12);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            run_left = idle_len();
         end
      end
   end

   // compare each result beat with the oldest prediction
   initial begin
      lifecycle_rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result: status %0d id %0h state %0d count %0d",
                        $time, rsp_status, rsp_entry_id, rsp_entry_state, rsp_active_count);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_entry_id !== want.entry_id) begin
                  $display("%0t: entry_id expected %0h actual %0h",
                           $time, want.entry_id, rsp_entry_id);
                  mismatches++;
               end
               if (rsp_entry_state !== want.entry_state) begin
                  $display("%0t: entry_state expected %0d actual %0d",
                           $time, want.entry_state, rsp_entry_state);
                  mismatches++;
               end
               if (rsp_active_count !== want.active_count) begin
                  $display("%0t: active_count expected %0d actual %0d",
                           $time, want.active_count, rsp_active_count);
                  mismatches++;
               end
            end
            results_checked++;
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      int idle;
      idle = 0;
      while (idle < IdleLimit) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) idle = 0;
         else idle++;
      end
      $display("%0t: no progress for %0d cycles", $time, IdleLimit);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/rlt_pkg.sv
hw/rtl/rlt_cell.sv
hw/rtl/request_lifecycle_table.sv
tb/tb_request_lifecycle_table.sv
